FILE: design/tari_pkg.sv
package tari_pkg;

  // Field widths of the packet header and the reset descriptor.
  localparam int ADDR_W = 32;
  localparam int PORT_W = 16;
  localparam int SEQ_W = 32;
  localparam int LEN_W = 16;
  localparam int CSUM_W = 16;

  // Stream and configuration port widths.
  localparam int IN_TDATA_W = 192;
  localparam int OUT_TDATA_W = 144;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int COUNT_W = 4;

  // The allowlist storage is four pairs of 32-bit addresses.
  localparam int MAX_ENTRIES = 8;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_ALLOWED_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ALLOWED_PAIR_0 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ALLOWED_PAIR_1 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ALLOWED_PAIR_2 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ALLOWED_PAIR_3 = 3'd4;

  // Protocol constants.
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [LEN_W-1:0] MIN_PACKET_BYTES = 16'd40;
  localparam logic [LEN_W-1:0] TCP_HDR_BYTES = 16'd20;
  localparam logic [15:0] OFFSET_AND_RST = 16'h5004;

  // One input item as it sits in s_tdata; the first member is the top bits.
  typedef struct packed {
    logic [2:0]        pad;
    logic              reset_set;
    logic [SEQ_W-1:0]  ack_number;
    logic [SEQ_W-1:0]  sequence_req;
    logic [PORT_W-1:0] dest_port;
    logic [PORT_W-1:0] source_port;
    logic [ADDR_W-1:0] dest_address;
    logic [ADDR_W-1:0] source_address;
    logic [LEN_W-1:0]  packet_length;
    logic [3:0]        header_words;
    logic [7:0]        protocol;
  } item_t;

  // The part of a reset descriptor that travels in m_tdata.
  typedef struct packed {
    logic [CSUM_W-1:0] rst_checksum;
    logic [SEQ_W-1:0]  rst_sequence;
    logic [PORT_W-1:0] rst_dest_port;
    logic [PORT_W-1:0] rst_source_port;
    logic [ADDR_W-1:0] rst_dest_address;
    logic [ADDR_W-1:0] rst_source_address;
  } desc_data_t;

  // A full descriptor with its sideband flags.
  typedef struct packed {
    logic       last_of_pair;
    logic       toward_sender;
    desc_data_t data;
  } desc_t;

  // Allowlist configuration as seen by the filter.
  typedef struct packed {
    logic [COUNT_W-1:0]                    count;
    logic [MAX_ENTRIES-1:0][ADDR_W-1:0]    entries;
  } allow_cfg_t;

  // Handoff between the input stage and the output sequencer.
  typedef struct packed {
    logic  load;
    desc_t back;
    desc_t fwd;
  } emit_req_t;

endpackage

FILE: design/tari_filter.sv
module tari_filter #(
  parameter int ALLOW_ENTRIES = 8
) (
  input  tari_pkg::item_t      item,
  input  tari_pkg::allow_cfg_t allow,
  output logic                 pass,
  output tari_pkg::desc_t      desc_back,
  output tari_pkg::desc_t      desc_fwd
);
  import tari_pkg::*;

  localparam int LIMIT = (ALLOW_ENTRIES > MAX_ENTRIES) ? MAX_ENTRIES : ALLOW_ENTRIES;
  localparam int ENTRY_W = $clog2(MAX_ENTRIES);

  // Ones-complement checksum over the pseudo-header and an RST-only header.
  function automatic logic [CSUM_W-1:0] reset_checksum(
    input logic [ADDR_W-1:0] src,
    input logic [ADDR_W-1:0] dst,
    input logic [PORT_W-1:0] sport,
    input logic [PORT_W-1:0] dport,
    input logic [SEQ_W-1:0]  seq
  );
    logic [19:0] sum;
    logic [16:0] fold;
    sum = 20'(src[31:16]) + 20'(src[15:0]) + 20'(dst[31:16]) + 20'(dst[15:0])
        + 20'(PROTO_TCP) + 20'(TCP_HDR_BYTES) + 20'(sport) + 20'(dport)
        + 20'(seq[31:16]) + 20'(seq[15:0]) + 20'(OFFSET_AND_RST);
    fold = 17'(sum[19:16]) + 17'(sum[15:0]);
    fold = 17'(fold[16]) + 17'(fold[15:0]);
    return ~fold[15:0];
  endfunction

  logic             listed;
  logic [6:0]       fit_need;
  logic [SEQ_W-1:0] seq_next;

  // Source address lookup against the valid part of the allowlist.
  always_comb begin
    listed = 1'b0;
    for (int k = 0; k < LIMIT; k++) begin
      if ((COUNT_W'(k) < allow.count)
          && (allow.entries[ENTRY_W'(k)] == item.source_address)) begin
        listed = 1'b1;
      end
    end
  end

  // Drop checks.
  assign fit_need = 7'({item.header_words, 2'b00}) + 7'(TCP_HDR_BYTES);

  assign pass = (item.protocol == PROTO_TCP)
             && (item.packet_length >= MIN_PACKET_BYTES)
             && (LEN_W'(fit_need) <= item.packet_length)
             && !item.reset_set
             && !listed;

  assign seq_next = item.sequence_req + 32'd1;

  // Reset back toward the sender: addresses and ports swapped, ack as sequence.
  always_comb begin
    desc_back.last_of_pair = 1'b0;
    desc_back.toward_sender = 1'b1;
    desc_back.data.rst_source_address = item.dest_address;
    desc_back.data.rst_dest_address = item.source_address;
    desc_back.data.rst_source_port = item.dest_port;
    desc_back.data.rst_dest_port = item.source_port;
    desc_back.data.rst_sequence = item.ack_number;
    desc_back.data.rst_checksum = reset_checksum(item.dest_address, item.source_address,
                                                 item.dest_port, item.source_port,
                                                 item.ack_number);
  end

  // Reset forward to the destination with the next sequence number.
  always_comb begin
    desc_fwd.last_of_pair = 1'b1;
    desc_fwd.toward_sender = 1'b0;
    desc_fwd.data.rst_source_address = item.source_address;
    desc_fwd.data.rst_dest_address = item.dest_address;
    desc_fwd.data.rst_source_port = item.source_port;
    desc_fwd.data.rst_dest_port = item.dest_port;
    desc_fwd.data.rst_sequence = seq_next;
    desc_fwd.data.rst_checksum = reset_checksum(item.source_address, item.dest_address,
                                                item.source_port, item.dest_port,
                                                seq_next);
  end

endmodule

FILE: design/tari_emit.sv
module tari_emit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tari_pkg::emit_req_t                  req,
  output logic                                 free,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [tari_pkg::OUT_TDATA_W-1:0]     m_tdata,   // rst_source_address, rst_dest_address,
                                                          // rst_source_port, rst_dest_port,
                                                          // rst_sequence, rst_checksum
  output logic                                 m_tuser,   // toward_sender
  output logic                                 m_tlast
);
  import tari_pkg::*;

  typedef enum logic [1:0] {
    EMPTY,
    FIRST_OUT,
    SECOND_OUT
  } phase_t;

  phase_t phase;
  desc_t  out_desc;
  desc_t  hold_desc;

  // A new pair can load when nothing is pending after this cycle.
  assign free = (phase == EMPTY) || ((phase == SECOND_OUT) && m_tready);

  // Output sequencer: the first descriptor goes out, the second waits behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= EMPTY;
    end else begin
      if (req.load && free) begin
        phase <= FIRST_OUT;
        out_desc <= req.back;
        hold_desc <= req.fwd;
      end else begin
        unique case (phase)
          FIRST_OUT: begin
            if (m_tready) begin
              phase <= SECOND_OUT;
              out_desc <= hold_desc;
            end
          end
          SECOND_OUT: begin
            if (m_tready) begin
              phase <= EMPTY;
            end
          end
          default: begin
            phase <= phase;
          end
        endcase
      end
    end
  end

  assign m_tvalid = (phase != EMPTY);
  assign m_tdata = out_desc.data;
  assign m_tuser = out_desc.toward_sender;
  assign m_tlast = out_desc.last_of_pair;

endmodule

FILE: design/tcp_allowlist_reset_injector_core.sv
// TCP reset injector with a source allowlist. Each item on the input stream
// carries the parsed header fields of one IPv4 packet. Packets that are not
// TCP, shorter than 40 bytes, whose TCP header does not fit, that already
// carry RST, or whose source is on the allowlist are dropped silently.
// Every other packet produces two reset descriptors on the output stream:
// first the one back toward the sender (tuser high), then the one forward
// to the destination (tlast high). The input item is held in an input
// register where the filter and both checksums are computed; the pair
// then moves into the output sequencer. A packet that produces resets
// holds the single output port for both descriptors, and the next pair
// loads as the second one is taken; dropped packets pass at one item per
// cycle unless a held packet waits ahead of them for the sequencer.
// Configuration writes take effect on the next cycle and should only be
// made while no packets are in flight.
module tcp_allowlist_reset_injector_core #(
  parameter int ALLOW_ENTRIES = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [tari_pkg::IN_TDATA_W-1:0]      s_tdata,   // protocol, header_words,
                                                          // packet_length, source_address,
                                                          // dest_address, source_port,
                                                          // dest_port, sequence_req,
                                                          // ack_number, reset_set
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [tari_pkg::OUT_TDATA_W-1:0]     m_tdata,   // rst_source_address, rst_dest_address,
                                                          // rst_source_port, rst_dest_port,
                                                          // rst_sequence, rst_checksum
  output logic                                 m_tuser,   // toward_sender
  output logic                                 m_tlast,   // last_of_pair
  input  logic                                 cfg_write,
  input  logic [tari_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tari_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tari_pkg::*;

  allow_cfg_t allow;
  logic       in_valid;
  item_t      in_item;
  logic       pass;
  logic       emit_free;
  logic       advance;
  desc_t      desc_back;
  desc_t      desc_fwd;
  emit_req_t  req;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      allow <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ALLOWED_COUNT: allow.count <= cfg_data[COUNT_W-1:0];
        REG_ALLOWED_PAIR_0: allow.entries[1:0] <= cfg_data;
        REG_ALLOWED_PAIR_1: allow.entries[3:2] <= cfg_data;
        REG_ALLOWED_PAIR_2: allow.entries[5:4] <= cfg_data;
        REG_ALLOWED_PAIR_3: allow.entries[7:6] <= cfg_data;
        default: allow <= allow;
      endcase
    end
  end

  // The held item leaves when it is dropped or the sequencer can take its pair.
  assign advance = in_valid && (!pass || emit_free);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= s_tdata;
    end
  end

  tari_filter #(
    .ALLOW_ENTRIES(ALLOW_ENTRIES)
  ) u_filter (
    .item      (in_item),
    .allow     (allow),
    .pass      (pass),
    .desc_back (desc_back),
    .desc_fwd  (desc_fwd)
  );

  assign req.load = in_valid && pass;
  assign req.back = desc_back;
  assign req.fwd = desc_fwd;

  tari_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .free     (emit_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: design/tari_checker.sv
module tari_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [tari_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                             m_tuser,
  input logic                             m_tlast
);
  import tari_pkg::*;

  // Nothing is offered right after reset.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A stalled output item holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output item changed");

  // Each descriptor is either the backward reset (tuser) or the forward reset that closes the pair (tlast).
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser != m_tlast))
    else $error("direction and pair position disagree");

  // The second descriptor follows the first without a gap.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
    else $error("second descriptor of the pair missing");

endmodule

bind tcp_allowlist_reset_injector_core tari_checker u_checker (.*);

FILE: tb/tb_tcp_allowlist_reset_injector_core.sv
module tb_tcp_allowlist_reset_injector_core;
  import tari_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ALLOW_ENTRIES = 8;
  localparam int IDLE_PCT = 22;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 6;
  localparam int WATCHDOG_LIMIT = 2000;

  // Indexes past the last register; writes there must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_5 = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Mirror of the allowlist registers.
  logic [COUNT_W-1:0] allow_count = '0;
  logic [63:0]        allow_pairs [4] = '{default: '0};

  item_t packet_queue [$];
  desc_t pending_resets [$];
  int    packets_queued = 0;
  int    packets_accepted = 0;
  int    mismatches = 0;
  int    quiet_cycles = 0;
  int    hold_left = 0;
  logic  hold_done = 1'b0;
  logic  stall_request = 1'b0;
  logic  no_gaps = 1'b0;

  tcp_allowlist_reset_injector_core #(
    .ALLOW_ENTRIES(ALLOW_ENTRIES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Allowlist entry k: even entries in the low half of a pair, odd in the high half.
  function automatic logic [31:0] allow_entry(int k);
    logic [63:0] pair;
    pair = allow_pairs[2'(k / 2)];
    return (k % 2 == 1) ? pair[63:32] : pair[31:0];
  endfunction

  function automatic logic source_listed(logic [31:0] addr);
    int limit;
    limit = (allow_count > ALLOW_ENTRIES) ? ALLOW_ENTRIES : int'(allow_count);
    for (int k = 0; k < limit; k++) begin
      if (allow_entry(k) == addr) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Ones-complement sum over the pseudo-header and a bare RST header.
  function automatic logic [15:0] reset_checksum(desc_data_t d);
    logic [31:0] sum;
    sum = d.rst_source_address[31:16] + d.rst_source_address[15:0]
        + d.rst_dest_address[31:16] + d.rst_dest_address[15:0]
        + 32'(PROTO_TCP) + 32'(TCP_HDR_BYTES)
        + d.rst_source_port + d.rst_dest_port
        + d.rst_sequence[31:16] + d.rst_sequence[15:0]
        + 32'(OFFSET_AND_RST);
    sum = sum[31:16] + sum[15:0];
    sum = sum + (sum >> 16);
    return ~sum[15:0];
  endfunction

  // Work out the reset pair a packet causes, if any, and queue it.
  function automatic void predict_resets(item_t pkt);
    desc_t back;
    desc_t fwd;
    if (pkt.protocol != PROTO_TCP) return;
    if (pkt.packet_length < MIN_PACKET_BYTES) return;
    if (int'(pkt.header_words) * 4 + int'(TCP_HDR_BYTES) > int'(pkt.packet_length)) return;
    if (pkt.reset_set) return;
    if (source_listed(pkt.source_address)) return;

    back.data.rst_source_address = pkt.dest_address;
    back.data.rst_dest_address   = pkt.source_address;
    back.data.rst_source_port    = pkt.dest_port;
    back.data.rst_dest_port      = pkt.source_port;
    back.data.rst_sequence       = pkt.ack_number;
    back.data.rst_checksum       = reset_checksum(back.data);
    back.toward_sender           = 1'b1;
    back.last_of_pair            = 1'b0;

    fwd.data.rst_source_address = pkt.source_address;
    fwd.data.rst_dest_address   = pkt.dest_address;
    fwd.data.rst_source_port    = pkt.source_port;
    fwd.data.rst_dest_port      = pkt.dest_port;
    fwd.data.rst_sequence       = pkt.sequence_req + 32'd1;
    fwd.data.rst_checksum       = reset_checksum(fwd.data);
    fwd.toward_sender           = 1'b0;
    fwd.last_of_pair            = 1'b1;

    pending_resets.push_back(back);
    pending_resets.push_back(fwd);
  endfunction

  function automatic item_t build_packet(logic [7:0] proto, logic [3:0] words,
                                         logic [15:0] len, logic [31:0] src, dst,
                                         logic [15:0] sport, dport,
                                         logic [31:0] seq, ack, logic rst_flag);
    item_t p;
    p = '0;
    p.protocol       = proto;
    p.header_words   = words;
    p.packet_length  = len;
    p.source_address = src;
    p.dest_address   = dst;
    p.source_port    = sport;
    p.dest_port      = dport;
    p.sequence_req   = seq;
    p.ack_number     = ack;
    p.reset_set      = rst_flag;
    return p;
  endfunction

  // Mostly well-formed TCP packets, the rest listed sources, each drop reason and noise.
  function automatic item_t make_random_packet();
    item_t p;
    int    roll;
    int    min_len;
    p = build_packet(PROTO_TCP, 4'($urandom_range(15)), 16'd0, $urandom, $urandom,
                     16'($urandom), 16'($urandom), $urandom, $urandom, 1'b0);
    min_len = int'(p.header_words) * 4 + int'(TCP_HDR_BYTES);
    if (min_len < int'(MIN_PACKET_BYTES)) min_len = int'(MIN_PACKET_BYTES);
    if ($urandom_range(1) == 1) begin
      p.packet_length = 16'($urandom_range(65535, min_len));
    end else begin
      p.packet_length = 16'(min_len + $urandom_range(40));
    end
    roll = $urandom_range(99);
    if (roll < 55) begin
      // Leave it as a packet that earns a reset pair.
    end else if (roll < 65) begin
      p.source_address = allow_entry($urandom_range(7));
    end else if (roll < 72) begin
      do p.protocol = 8'($urandom_range(255)); while (p.protocol == PROTO_TCP);
    end else if (roll < 79) begin
      p.packet_length = 16'($urandom_range(39));
    end else if (roll < 86) begin
      p.header_words = 4'($urandom_range(15, 6));
      p.packet_length = 16'($urandom_range(int'(p.header_words) * 4 + 19, 40));
    end else if (roll < 93) begin
      p.reset_set = 1'b1;
    end else begin
      p.protocol      = 8'($urandom);
      p.header_words  = 4'($urandom);
      p.packet_length = 16'($urandom);
      p.reset_set     = 1'($urandom);
    end
    return p;
  endfunction

  task automatic queue_packet(item_t p);
    packet_queue.push_back(p);
    packets_queued++;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH at %0t: %s got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == REG_ALLOWED_COUNT) begin
      allow_count = value[COUNT_W-1:0];
    end else if (idx >= REG_ALLOWED_PAIR_0 && idx <= REG_ALLOWED_PAIR_3) begin
      allow_pairs[2'(idx - REG_ALLOWED_PAIR_0)] = value;
    end
  endtask

  task automatic program_allowlist(logic [COUNT_W-1:0] count, logic [63:0] p0, p1, p2, p3);
    write_register(REG_ALLOWED_COUNT, CFG_DATA_W'(count));
    write_register(REG_ALLOWED_PAIR_0, p0);
    write_register(REG_ALLOWED_PAIR_1, p1);
    write_register(REG_ALLOWED_PAIR_2, p2);
    write_register(REG_ALLOWED_PAIR_3, p3);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Wait until every packet is taken and every reset has come out, then let
  // a dropped packet still inside the block pass through.
  task automatic drain();
    while (packets_accepted != packets_queued || pending_resets.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(int count);
    repeat (count) queue_packet(make_random_packet());
    drain();
  endtask

  // Sender: offers the next pending item, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_resets(item_t'(s_tdata));
        packets_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (packet_queue.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
          s_tdata  <= packet_queue.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness, with one long hold-off when asked for.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (stall_request && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare each delivered descriptor with the oldest expected one.
  always @(posedge clk) begin : monitor
    desc_data_t seen;
    desc_t      want;
    if (!rst && m_tvalid && m_tready) begin
      seen = m_tdata;
      if (pending_resets.size() == 0) begin
        report_mismatch("descriptor with no reset pending", m_tdata[63:0], '0);
      end else begin
        want = pending_resets.pop_front();
        if (seen.rst_source_address !== want.data.rst_source_address)
          report_mismatch("rst_source_address", 64'(seen.rst_source_address),
                          64'(want.data.rst_source_address));
        if (seen.rst_dest_address !== want.data.rst_dest_address)
          report_mismatch("rst_dest_address", 64'(seen.rst_dest_address),
                          64'(want.data.rst_dest_address));
        if (seen.rst_source_port !== want.data.rst_source_port)
          report_mismatch("rst_source_port", 64'(seen.rst_source_port),
                          64'(want.data.rst_source_port));
        if (seen.rst_dest_port !== want.data.rst_dest_port)
          report_mismatch("rst_dest_port", 64'(seen.rst_dest_port),
                          64'(want.data.rst_dest_port));
        if (seen.rst_sequence !== want.data.rst_sequence)
          report_mismatch("rst_sequence", 64'(seen.rst_sequence),
                          64'(want.data.rst_sequence));
        if (seen.rst_checksum !== want.data.rst_checksum)
          report_mismatch("rst_checksum", 64'(seen.rst_checksum),
                          64'(want.data.rst_checksum));
        if (m_tuser !== want.toward_sender)
          report_mismatch("toward_sender", 64'(m_tuser), 64'(want.toward_sender));
        if (m_tlast !== want.last_of_pair)
          report_mismatch("last_of_pair", 64'(m_tlast), 64'(want.last_of_pair));
      end
    end
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tcp_allowlist_reset_injector_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: empty allowlist, so address zero is not listed.
    queue_packet(build_packet(PROTO_TCP, 4'd5, 16'd40, 32'h0a00_0001, 32'h0a00_0002,
                              16'd1234, 16'd80, 32'h0000_1000, 32'h0000_2000, 1'b0));
    queue_packet(build_packet(PROTO_TCP, 4'd15, 16'hffff, '1, '1, '1, '1, '1, '1, 1'b0));
    queue_packet(build_packet(PROTO_TCP, 4'd0, 16'd40, '0, '0, '0, '0, '0, '0, 1'b0));
    // Drops: short IP header words with a short length, non-TCP protocols, a short TCP packet.
    queue_packet(build_packet(PROTO_TCP, 4'd4, 16'd39, $urandom, $urandom,
                              16'd7, 16'd8, $urandom, $urandom, 1'b0));
    queue_packet(build_packet(8'd0, 4'd5, 16'd60, $urandom, $urandom,
                              16'd1, 16'd2, $urandom, $urandom, 1'b0));
    queue_packet(build_packet(8'd255, 4'd5, 16'd60, $urandom, $urandom,
                              16'd1, 16'd2, $urandom, $urandom, 1'b0));
    queue_packet(build_packet(8'd17, 4'd5, 16'd60, $urandom, $urandom,
                              16'd1, 16'd2, $urandom, $urandom, 1'b0));
    queue_packet(build_packet(PROTO_TCP, 4'd5, 16'd39, $urandom, $urandom,
                              16'd3, 16'd4, $urandom, $urandom, 1'b0));
    // Fit check at its edges.
    queue_packet(build_packet(PROTO_TCP, 4'd6, 16'd43, $urandom, $urandom,
                              16'd5, 16'd6, $urandom, $urandom, 1'b0));
    queue_packet(build_packet(PROTO_TCP, 4'd6, 16'd44, $urandom, $urandom,
                              16'd5, 16'd6, $urandom, $urandom, 1'b0));
    queue_packet(build_packet(PROTO_TCP, 4'd15, 16'd79, $urandom, $urandom,
                              16'd9, 16'd10, $urandom, $urandom, 1'b0));
    queue_packet(build_packet(PROTO_TCP, 4'd15, 16'd80, $urandom, $urandom,
                              16'd9, 16'd10, $urandom, $urandom, 1'b0));
    queue_packet(build_packet(PROTO_TCP, 4'd5, 16'd100, $urandom, $urandom,
                              16'd11, 16'd12, $urandom, $urandom, 1'b1));
    // Sequence wraps to zero on the forward reset.
    queue_packet(build_packet(PROTO_TCP, 4'd5, 16'd1500, $urandom, $urandom,
                              16'hffff, 16'd0, 32'hffff_ffff, 32'd0, 1'b0));
    run_random(100);

    // Spare indexes first, then a partly used list with entries past the count.
    write_register(REG_SPARE_5, '1);
    write_register(REG_SPARE_6, '1);
    write_register(REG_SPARE_7, '1);
    program_allowlist(4'd3, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
    for (int k = 0; k < ALLOW_ENTRIES; k++) begin
      queue_packet(build_packet(PROTO_TCP, 4'd5, 16'd60, allow_entry(k), $urandom,
                                16'($urandom), 16'($urandom), $urandom, $urandom, 1'b0));
    end
    run_random(300);

    // Full list, with neither side pausing.
    program_allowlist(4'd8, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
    no_gaps <= 1'b1;
    run_random(500);
    no_gaps <= 1'b0;

    // Count above the table size saturates; the receiver holds off meanwhile.
    program_allowlist(4'd15, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, '1);
    stall_request <= 1'b1;
    queue_packet(build_packet(PROTO_TCP, 4'd5, 16'd60, allow_entry(7), $urandom,
                              16'($urandom), 16'($urandom), $urandom, $urandom, 1'b0));
    queue_packet(build_packet(PROTO_TCP, 4'd5, 16'd60, allow_entry(0), $urandom,
                              16'($urandom), 16'($urandom), $urandom, $urandom, 1'b0));
    run_random(600);

    program_allowlist(4'd9, '0, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom});
    run_random(300);

    program_allowlist(4'd1, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
    run_random(200);

    // Entries present but count zero: nothing is listed.
    program_allowlist(4'd0, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
    run_random(100);

    if (mismatches == 0) begin
      $display("tcp_allowlist_reset_injector_core verification clean");
    end else begin
      $display("tcp_allowlist_reset_injector_core verification failed");
    end
    $finish;
  end

endmodule

FILE: tcp_allowlist_reset_injector_core.f
design/tari_pkg.sv
design/tari_filter.sv
design/tari_emit.sv
design/tcp_allowlist_reset_injector_core.sv
design/tari_checker.sv
tb/tb_tcp_allowlist_reset_injector_core.sv
